/* design/wtts_pkg.sv */
// Shared types and constants for the watch-table trace sampler.
// No dependencies; every other design file imports this package.
package wtts_pkg;

	localparam int unsigned MAX_RANGES = 3;

	// input beat kinds
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_ENTRY = 2'd1;
	localparam logic [1:0] KIND_COUNT = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_COUNT = 2'd1;
	localparam logic [1:0] ST_BAD_ADDR  = 2'd2;

	// configuration register indexes
	localparam logic [2:0] CFG_LO0  = 3'd0;
	localparam logic [2:0] CFG_HI0  = 3'd1;
	localparam logic [2:0] CFG_LO1  = 3'd2;
	localparam logic [2:0] CFG_HI1  = 3'd3;
	localparam logic [2:0] CFG_LO2  = 3'd4;
	localparam logic [2:0] CFG_HI2  = 3'd5;
	localparam logic [2:0] CFG_USED = 3'd6;

	// compare unit operations
	localparam logic CMP_EQ    = 1'b0;
	localparam logic CMP_RANGE = 1'b1;

	typedef struct packed {
		logic [MAX_RANGES-1:0][31:0] lo;
		logic [MAX_RANGES-1:0][31:0] hi;
		logic [1:0]                  used;
	} cfg_t;

endpackage

/* design/wtts_cfg.sv */
// Whitelist range configuration registers of the trace sampler.
// Depends on wtts_pkg for the register indexes and the cfg_t bundle.
module wtts_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	output wtts_pkg::cfg_t    cfg
);
	import wtts_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_LO0:  cfg_q.lo[0] <= cfg_data;
				CFG_HI0:  cfg_q.hi[0] <= cfg_data;
				CFG_LO1:  cfg_q.lo[1] <= cfg_data;
				CFG_HI1:  cfg_q.hi[1] <= cfg_data;
				CFG_LO2:  cfg_q.lo[2] <= cfg_data;
				CFG_HI2:  cfg_q.hi[2] <= cfg_data;
				CFG_USED: cfg_q.used  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* design/wtts_cmp.sv */
// Shared 32-bit compare unit: entry equality or whitelist range check.
// Depends on wtts_pkg for the operation codes.
module wtts_cmp (
	input  logic        op,
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [31:0] c,
	output logic        hit
);
	import wtts_pkg::*;

	logic [31:0] top;

	// last word start inside [b, c); wraps modulo 2^32
	assign top = c - 32'd4;

	always_comb begin
		case (op)
			CMP_EQ:    hit = (a == b);
			CMP_RANGE: hit = (a[1:0] == 2'b00) && (a >= b) && (a <= top);
			default:   hit = 1'b0;
		endcase
	end

endmodule

/* design/watch_table_trace_sampler.sv */
// Watch-table trace sampler. A table write or count write (start with kind 1 or 2) is taken
// only while idle and never raises busy. A tick (kind 0) with a zero live count or a count
// above CHANNELS goes straight to emitting. Otherwise, if the live count equals the snapshot
// count, it first compares the live table against the accepted snapshot, one entry per cycle;
// if they differ (or the counts differ) it checks each live entry against the whitelist ranges,
// one entry/range pair per cycle, all on one shared 32-bit compare unit. It then emits CHANNELS
// results on consecutive cycles, each marked by result_valid for one cycle; the receiver cannot
// stall them. busy is high from the accepting edge until the last result is registered.
// Depends on wtts_pkg, wtts_cfg and wtts_cmp.
module watch_table_trace_sampler #(
	parameter int CHANNELS     = 8,
	parameter int RING_RECORDS = 64,
	parameter int RANGES       = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [2:0]  entry_index,
	input  logic [31:0] write_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic        result_valid,
	output logic [31:0] record_seq,
	output logic [31:0] record_gen,
	output logic [5:0]  ring_index,
	output logic [2:0]  slot_index,
	output logic [31:0] slot_address,
	output logic        slot_active,
	output logic [1:0]  status_now,
	output logic [7:0]  count_now,
	output logic        last_slot
);
	import wtts_pkg::*;

	localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int AW = $clog2(CHANNELS + 1);
	localparam int RW = (RING_RECORDS > 1) ? $clog2(RING_RECORDS) : 1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CMP  = 2'd1;
	localparam logic [1:0] S_ADDR = 2'd2;
	localparam logic [1:0] S_EMIT = 2'd3;

	cfg_t cfg;

	logic [1:0]          state_q;
	logic [IW-1:0]       i_q;
	logic [1:0]          k_q;
	logic [31:0]         watch_q [CHANNELS];
	logic [31:0]         acc_q   [CHANNELS];
	logic [7:0]          live_q;
	logic [AW-1:0]       acc_count_q;
	logic [31:0]         gen_q;
	logic [1:0]          status_q;
	logic [31:0]         seq_q;
	logic [RW-1:0]       ring_q;
	logic                result_valid_q;

	logic [31:0] seq_out_q, gen_out_q, addr_out_q;
	logic [5:0]  ring_out_q;
	logic [2:0]  slot_out_q;
	logic        active_out_q, last_out_q;
	logic [1:0]  status_out_q;
	logic [7:0]  count_out_q;

	logic [31:0] watch_rd, acc_rd;
	logic        cmp_op, cmp_hit;
	logic [31:0] cmp_b;
	logic [1:0]  nr;
	logic        last_entry, addr_hit, k_last, slot_live, last_emit;

	wtts_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign watch_rd = watch_q[i_q];
	assign acc_rd   = acc_q[i_q];
	assign cmp_op   = (state_q == S_ADDR) ? CMP_RANGE : CMP_EQ;
	assign cmp_b    = (state_q == S_ADDR) ? cfg.lo[k_q] : acc_rd;

	wtts_cmp u_cmp (
		.op  (cmp_op),
		.a   (watch_rd),
		.b   (cmp_b),
		.c   (cfg.hi[k_q]),
		.hit (cmp_hit)
	);

	assign nr         = (cfg.used > 2'(RANGES)) ? 2'(RANGES) : cfg.used;
	assign last_entry = ((8'(i_q) + 8'd1) == live_q);
	assign addr_hit   = cmp_hit && ({1'b0, k_q} < {1'b0, nr});
	assign k_last     = (({1'b0, k_q} + 3'd1) >= {1'b0, nr});
	assign slot_live  = (8'(i_q) < live_q);
	assign last_emit  = (i_q == IW'(CHANNELS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			i_q            <= '0;
			k_q            <= '0;
			live_q         <= '0;
			acc_count_q    <= '0;
			gen_q          <= '0;
			status_q       <= ST_OK;
			seq_q          <= '0;
			ring_q         <= '0;
			result_valid_q <= 1'b0;
			for (int n = 0; n < CHANNELS; n++) begin
				watch_q[n] <= '0;
				acc_q[n]   <= '0;
			end
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						case (kind)
							KIND_TICK: begin
								i_q <= '0;
								k_q <= '0;
								if (live_q == 8'd0) begin
									acc_count_q <= '0;
									state_q     <= S_EMIT;
								end else if (live_q != 8'(acc_count_q)) begin
									if (live_q > 8'(CHANNELS)) begin
										status_q    <= ST_BAD_COUNT;
										live_q      <= '0;
										acc_count_q <= '0;
										state_q     <= S_EMIT;
									end else begin
										state_q <= S_ADDR;
									end
								end else begin
									state_q <= S_CMP;
								end
							end
							KIND_ENTRY: begin
								if (32'(entry_index) < 32'(CHANNELS))
									watch_q[IW'(entry_index)] <= write_value;
							end
							KIND_COUNT: begin
								live_q <= (write_value > 32'd255) ? 8'd255 : write_value[7:0];
							end
							default: ;
						endcase
					end
				end
				S_CMP: begin
					// walk the live entries until one differs from the snapshot
					if (!cmp_hit) begin
						i_q     <= '0;
						k_q     <= '0;
						state_q <= S_ADDR;
					end else if (last_entry) begin
						i_q     <= '0;
						state_q <= S_EMIT;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_ADDR: begin
					if (addr_hit) begin
						// snapshot entries above the count are never read
						acc_q[i_q] <= watch_rd;
						k_q        <= '0;
						if (last_entry) begin
							acc_count_q <= AW'(live_q);
							gen_q       <= gen_q + 32'd1;
							status_q    <= ST_OK;
							i_q         <= '0;
							state_q     <= S_EMIT;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end else if (k_last) begin
						status_q    <= ST_BAD_ADDR;
						live_q      <= '0;
						acc_count_q <= '0;
						i_q         <= '0;
						state_q     <= S_EMIT;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				S_EMIT: begin
					result_valid_q <= 1'b1;
					if (last_emit) begin
						seq_q <= seq_q + 32'd1;
						// keep ring equal to seq modulo the ring size, also across the wrap
						if (seq_q == '1 || ring_q == RW'(RING_RECORDS - 1))
							ring_q <= '0;
						else
							ring_q <= ring_q + 1'b1;
						state_q <= S_IDLE;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT) begin
			seq_out_q    <= seq_q;
			gen_out_q    <= gen_q;
			ring_out_q   <= 6'(ring_q);
			slot_out_q   <= 3'(i_q);
			addr_out_q   <= slot_live ? watch_rd : 32'd0;
			active_out_q <= slot_live;
			status_out_q <= status_q;
			count_out_q  <= live_q;
			last_out_q   <= last_emit;
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign record_seq   = seq_out_q;
	assign record_gen   = gen_out_q;
	assign ring_index   = ring_out_q;
	assign slot_index   = slot_out_q;
	assign slot_address = addr_out_q;
	assign slot_active  = active_out_q;
	assign status_now   = status_out_q;
	assign count_now    = count_out_q;
	assign last_slot    = last_out_q;

endmodule

/* tb/sv/tb_watch_table_trace_sampler.sv */
// Self-checking bench for watch_table_trace_sampler: drives host beats and register writes,
// predicts each tick's slot records and compares them field by field as they stream out.
// Depends on wtts_pkg and the design sources only.
module tb_watch_table_trace_sampler;
	import wtts_pkg::*;

	localparam int CH          = 8;
	localparam int RING        = 64;
	localparam int DRAIN       = 60;
	localparam int QUIET_LIMIT = 1500;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	typedef struct {
		logic [31:0] rec_seq;
		logic [31:0] rec_gen;
		logic [5:0]  ring;
		logic [2:0]  slot;
		logic [31:0] addr;
		logic        active;
		logic [1:0]  status;
		logic [7:0]  count;
		logic        last;
	} slot_rec_t;

	class slot_record_checker;
		logic [31:0] range_lo [MAX_RANGES];
		logic [31:0] range_hi [MAX_RANGES];
		logic [1:0]  ranges_on;
		logic [31:0] watch_tbl [CH];
		logic [31:0] snap_tbl [CH];
		logic [7:0]  live_cnt;
		logic [3:0]  snap_cnt;
		logic [31:0] gen_cnt;
		logic [1:0]  status;
		logic [31:0] next_seq;
		slot_rec_t   expected_slots [$];
		int          errors;
		int          checked;

		function new();
			for (int k = 0; k < MAX_RANGES; k++) begin
				range_lo[k] = '0;
				range_hi[k] = '0;
			end
			for (int i = 0; i < CH; i++) begin
				watch_tbl[i] = '0;
				snap_tbl[i] = '0;
			end
			ranges_on = '0;
			live_cnt = '0;
			snap_cnt = '0;
			gen_cnt = '0;
			status = ST_OK;
			next_seq = '0;
			errors = 0;
			checked = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] v);
			case (idx)
				CFG_LO0:  range_lo[0] = v;
				CFG_HI0:  range_hi[0] = v;
				CFG_LO1:  range_lo[1] = v;
				CFG_HI1:  range_hi[1] = v;
				CFG_LO2:  range_lo[2] = v;
				CFG_HI2:  range_hi[2] = v;
				CFG_USED: ranges_on = v[1:0];
				default: ;
			endcase
		endfunction

		// whole word must sit in [lo, hi); hi - 4 wraps like the hardware
		function bit addr_ok(logic [31:0] a);
			logic [31:0] top;
			int n;
			if (a[1:0] != 2'b00)
				return 1'b0;
			n = (ranges_on > MAX_RANGES) ? MAX_RANGES : ranges_on;
			for (int k = 0; k < n; k++) begin
				top = range_hi[k] - 32'd4;
				if (a >= range_lo[k] && a <= top)
					return 1'b1;
			end
			return 1'b0;
		endfunction

		function void revalidate();
			bit differs;
			int n;
			n = live_cnt;
			if (n == 0) begin
				snap_cnt = '0;
				return;
			end
			differs = (n != snap_cnt);
			for (int i = 0; !differs && i < n && i < CH; i++)
				if (watch_tbl[i] != snap_tbl[i])
					differs = 1'b1;
			if (!differs)
				return;
			if (n > CH) begin
				status = ST_BAD_COUNT;
				live_cnt = '0;
				snap_cnt = '0;
				return;
			end
			for (int i = 0; i < n; i++)
				if (!addr_ok(watch_tbl[i])) begin
					status = ST_BAD_ADDR;
					live_cnt = '0;
					snap_cnt = '0;
					return;
				end
			snap_cnt = n[3:0];
			for (int i = 0; i < n; i++)
				snap_tbl[i] = watch_tbl[i];
			gen_cnt = gen_cnt + 32'd1;
			status = ST_OK;
		endfunction

		function void note_item(logic [1:0] k, logic [2:0] idx, logic [31:0] v);
			slot_rec_t r;
			case (k)
				KIND_ENTRY: watch_tbl[idx] = v;
				KIND_COUNT: live_cnt = (v > 32'd255) ? 8'hFF : v[7:0];
				KIND_TICK: begin
					revalidate();
					for (int i = 0; i < CH; i++) begin
						r.rec_seq = next_seq;
						r.rec_gen = gen_cnt;
						r.ring    = 6'(next_seq % RING);
						r.slot    = i[2:0];
						r.active  = (i < live_cnt);
						r.addr    = r.active ? watch_tbl[i] : 32'd0;
						r.status  = status;
						r.count   = live_cnt;
						r.last    = (i == CH - 1);
						expected_slots.push_back(r);
					end
					next_seq = next_seq + 32'd1;
				end
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_slots.size();
		endfunction

		task report(string msg);
			errors++;
			$display("mismatch at %0t: %s", $time, msg);
		endtask

		task compare_field(string where, string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report($sformatf("%s %s got %h want %h", where, name, got, want));
		endtask

		task check(slot_rec_t got);
			slot_rec_t want;
			string where;
			if (expected_slots.size() == 0) begin
				report($sformatf("unexpected result seq %0d slot %0d", got.rec_seq, got.slot));
				return;
			end
			want = expected_slots.pop_front();
			checked++;
			where = $sformatf("seq %0d slot %0d:", want.rec_seq, want.slot);
			compare_field(where, "record_seq", got.rec_seq, want.rec_seq);
			compare_field(where, "record_gen", got.rec_gen, want.rec_gen);
			compare_field(where, "ring_index", 32'(got.ring), 32'(want.ring));
			compare_field(where, "slot_index", 32'(got.slot), 32'(want.slot));
			compare_field(where, "slot_address", got.addr, want.addr);
			compare_field(where, "slot_active", 32'(got.active), 32'(want.active));
			compare_field(where, "status_now", 32'(got.status), 32'(want.status));
			compare_field(where, "count_now", 32'(got.count), 32'(want.count));
			compare_field(where, "last_slot", 32'(got.last), 32'(want.last));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  kind;
	logic [2:0]  entry_index;
	logic [31:0] write_value;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        result_valid;
	logic [31:0] record_seq;
	logic [31:0] record_gen;
	logic [5:0]  ring_index;
	logic [2:0]  slot_index;
	logic [31:0] slot_address;
	logic        slot_active;
	logic [1:0]  status_now;
	logic [7:0]  count_now;
	logic        last_slot;

	slot_record_checker score;
	logic [31:0] cfg_lo [MAX_RANGES];
	logic [31:0] cfg_hi [MAX_RANGES];
	logic [1:0]  cfg_used;
	bit          idle_on;
	int          items;
	int          ticks;
	int          reg_writes;
	int          quiet;

	watch_table_trace_sampler dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.entry_index(entry_index), .write_value(write_value), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.result_valid(result_valid), .record_seq(record_seq), .record_gen(record_gen),
		.ring_index(ring_index), .slot_index(slot_index), .slot_address(slot_address),
		.slot_active(slot_active), .status_now(status_now), .count_now(count_now),
		.last_slot(last_slot)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin : result_monitor
		slot_rec_t seen;
		if (arst_n && result_valid) begin
			seen.rec_seq = record_seq;
			seen.rec_gen = record_gen;
			seen.ring    = ring_index;
			seen.slot    = slot_index;
			seen.addr    = slot_address;
			seen.active  = slot_active;
			seen.status  = status_now;
			seen.count   = count_now;
			seen.last    = last_slot;
			score.check(seen);
		end
	end

	// count cycles in which no beat moves anywhere
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("timeout: no beat for %0d cycles", QUIET_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// called at a falling edge; returns at the falling edge after the beat is taken
	task automatic send(input logic [1:0] k, input logic [2:0] idx, input logic [31:0] v);
		int gap;
		if (idle_on && $urandom_range(99) < 36) begin
			gap = ($urandom_range(3) == 0) ? $urandom_range(40, 8) : $urandom_range(4, 1);
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		kind = k;
		entry_index = idx;
		write_value = v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		score.note_item(k, idx, v);
		if (k != KIND_UNUSED)
			items++;
		if (k == KIND_TICK)
			ticks++;
		@(negedge clk);
	endtask

	task automatic write_cfg(input logic [2:0] idx, input logic [31:0] v);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		score.set_reg(idx, v);
		case (idx)
			CFG_LO0:  cfg_lo[0] = v;
			CFG_HI0:  cfg_hi[0] = v;
			CFG_LO1:  cfg_lo[1] = v;
			CFG_HI1:  cfg_hi[1] = v;
			CFG_LO2:  cfg_lo[2] = v;
			CFG_HI2:  cfg_hi[2] = v;
			CFG_USED: cfg_used = v[1:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
	endtask

	task automatic configure(input logic [31:0] lo0, hi0, lo1, hi1, lo2, hi2, used_word);
		write_cfg(CFG_LO0, lo0);
		write_cfg(CFG_HI0, hi0);
		write_cfg(CFG_LO1, lo1);
		write_cfg(CFG_HI1, hi1);
		write_cfg(CFG_LO2, lo2);
		write_cfg(CFG_HI2, hi2);
		write_cfg(CFG_USED, used_word);
		cfg_valid = 1'b0;
	endtask

	// hold until every record is out and the block has gone quiet
	task automatic settle();
		start = 1'b0;
		while (score.pending() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		@(negedge clk);
	endtask

	// mostly whitelisted words, with boundaries, one-past-the-end and noise
	function automatic logic [31:0] pick_addr();
		int k;
		logic [31:0] lo;
		logic [31:0] top;
		logic [31:0] a;
		logic [63:0] span;
		if (cfg_used == 2'd0 || $urandom_range(99) < 12)
			return $urandom;
		k = $urandom_range(cfg_used - 1);
		lo = cfg_lo[k];
		top = cfg_hi[k] - 32'd4;
		if (top < lo)
			return $urandom;
		case ($urandom_range(5))
			0: a = lo;
			1: a = top;
			2: a = top + 32'd4;
			default: begin
				span = 64'(top - lo) + 64'd1;
				a = lo + 32'({32'd0, $urandom} % span);
				a[1:0] = 2'b00;
				if (a < lo)
					a = a + 32'd4;
			end
		endcase
		return a;
	endfunction

	task automatic random_burst();
		int r;
		int n;
		logic [2:0] idx;
		logic [31:0] v;
		r = $urandom_range(99);
		if (r < 70) begin
			n = $urandom_range(CH, 1);
			for (int i = 0; i < n; i++) begin
				idx = ($urandom_range(3) != 0) ? i[2:0] : 3'($urandom_range(7));
				send(KIND_ENTRY, idx, pick_addr());
			end
			v = ($urandom_range(9) == 0) ? $urandom_range(CH + 2) : n;
			send(KIND_COUNT, 3'($urandom_range(7)), v);
			repeat ($urandom_range(2, 1))
				send(KIND_TICK, 3'($urandom_range(7)), $urandom);
		end else if (r < 85) begin
			send(KIND_TICK, 3'($urandom_range(7)), $urandom);
		end else begin
			v = $urandom_range(1) ? $urandom : $urandom_range(12);
			send(2'($urandom_range(3)), 3'($urandom_range(7)), v);
		end
	endtask

	task automatic random_phase(input int quota);
		int target;
		target = items + quota;
		while (items < target)
			random_burst();
	endtask

	initial begin
		score = new();
		arst_n = 1'b0;
		start = 1'b0;
		kind = KIND_TICK;
		entry_index = '0;
		write_value = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_LO0;
		cfg_data = '0;
		cfg_used = '0;
		for (int k = 0; k < MAX_RANGES; k++) begin
			cfg_lo[k] = '0;
			cfg_hi[k] = '0;
		end
		idle_on = 1'b1;
		items = 0;
		ticks = 0;
		reg_writes = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// range one runs to the top of memory through a wrapped bound; range two is unchecked
		configure(32'h0000_1000, 32'h0000_2000, 32'h8000_0000, 32'h0000_0000,
			32'h0000_0040, 32'h0000_0050, 32'hFFFF_FFFE);
		send(KIND_TICK, 3'd0, 32'd0);
		send(KIND_UNUSED, 3'd7, 32'hFFFF_FFFF);
		for (int i = 0; i < 6; i++)
			send(KIND_ENTRY, i[2:0], 32'h0000_1000 + 32'(4 * i));
		send(KIND_ENTRY, 3'd6, 32'h8000_0000);
		send(KIND_ENTRY, 3'd7, 32'hFFFF_FFFC);
		send(KIND_COUNT, 3'd0, 32'd8);
		send(KIND_TICK, 3'd7, 32'hFFFF_FFFF);
		send(KIND_TICK, 3'd0, 32'd0);
		send(KIND_COUNT, 3'd0, 32'd9);
		send(KIND_TICK, 3'd0, 32'd0);
		send(KIND_COUNT, 3'd0, 32'hFFFF_FFFF);
		send(KIND_TICK, 3'd0, 32'd0);
		send(KIND_ENTRY, 3'd2, 32'h0000_1002);
		send(KIND_COUNT, 3'd0, 32'd3);
		send(KIND_TICK, 3'd0, 32'd0);
		send(KIND_ENTRY, 3'd2, 32'h0000_2000);
		send(KIND_COUNT, 3'd0, 32'd3);
		send(KIND_TICK, 3'd0, 32'd0);
		send(KIND_ENTRY, 3'd2, 32'h0000_0040);
		send(KIND_TICK, 3'd0, 32'd0);
		send(KIND_ENTRY, 3'd2, 32'h0000_1FFC);
		send(KIND_COUNT, 3'd0, 32'd3);
		send(KIND_TICK, 3'd0, 32'd0);
		send(KIND_COUNT, 3'd0, 32'd0);
		send(KIND_TICK, 3'd0, 32'd0);

		// widest ranges, run back to back with no idle gaps
		settle();
		configure(32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF,
			32'hFFFF_FFFF);
		idle_on = 1'b0;
		random_phase(90);
		idle_on = 1'b1;

		// no range checked: every changed table with a nonzero count must be rejected
		settle();
		configure(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		random_phase(60);

		// narrow random ranges
		settle();
		configure($urandom, 32'd0, $urandom, 32'd0, $urandom, 32'd0, 32'd3);
		for (int k = 0; k < MAX_RANGES; k++)
			write_cfg(3'(2 * k + 1), cfg_lo[k] + 32'($urandom_range(64, 0)));
		cfg_valid = 1'b0;
		random_phase(100);

		// tiny upper bounds wrap hi - 4; a single-word range; an empty top range
		settle();
		configure(32'hFFFF_0000, 32'd2, 32'h0000_0040, 32'h0000_0044, 32'hFFFF_FFFF,
			32'd0, 32'h5555_5553);
		random_phase(110);

		settle();
		configure($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 32'd1);
		random_phase(80);

		start = 1'b0;
		while (score.pending() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		$display("covered %0d host beats, %0d ticks, %0d register writes", items, ticks,
			reg_writes);
		$display("checked %0d slot results, %0d mismatches", score.checked, score.errors);
		if (score.errors == 0 && score.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
